[hw/rtl/radix_digit_serial_alu_assert.svh]
// Assertion macros for the radix digit-serial ALU.
// Included by the top level; needs nothing else.
`ifndef RADIX_DIGIT_SERIAL_ALU_ASSERT_SVH
`define RADIX_DIGIT_SERIAL_ALU_ASSERT_SVH
`ifndef ASSERT_OFF
`define RDSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdsa: same-cycle check failed");
`define RDSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdsa: next-cycle check failed");
`else
`define RDSA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RDSA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/rdsa_pkg.sv]
// Shared types and constants for the radix digit-serial ALU.
// No dependencies.
`default_nettype none
package rdsa_pkg;

    localparam int MAX_RADIX = 16;
    localparam logic [4:0] RADIX_RESET = 5'd10;
    localparam logic [4:0] RADIX_MIN   = 5'd2;
    localparam logic [4:0] RADIX_MAX   = 5'(MAX_RADIX);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_NEG   = 2'd1;
    localparam logic [1:0] ERR_DIV0  = 2'd2;
    localparam logic [1:0] ERR_RANGE = 2'd3;

    // task queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // result queue inside the back end
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = OUT_AW + 1;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] digit_a;
        logic [3:0] digit_b;
        logic       first;
        logic       last;
        logic [1:0] err;     // precomputed range / zero-divisor class
        logic [4:0] radix;   // clamped radix
    } t_task;

    typedef struct packed {
        logic [3:0] digit;
        logic [3:0] rem;
        logic       last;
        logic [1:0] err;
    } t_result;

    typedef struct packed {
        logic              busy;
        logic [OUT_CW-1:0] out_count;
    } t_back_stat;

endpackage
`default_nettype wire

[hw/rtl/rdsa_front.sv]
// Front end: radix register, input acceptance and item classification.
// Depends on rdsa_pkg.
`default_nettype none
module rdsa_front
    import rdsa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [4:0] i_cfg_radix,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_op,
    input  wire logic [3:0] i_digit_a,
    input  wire logic [3:0] i_digit_b,
    input  wire logic       i_first_digit,
    input  wire logic       i_last_digit,
    input  wire logic       i_q_full,
    output logic            o_q_push,
    output t_task           o_task
);

    logic [4:0] r_radix;
    logic [4:0] eff_radix;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_radix <= i_cfg_radix;
        end
    end

    always_comb begin
        if (r_radix < RADIX_MIN) begin
            eff_radix = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            eff_radix = RADIX_MAX;
        end else begin
            eff_radix = r_radix;
        end
    end

    always_comb begin
        o_task.op      = i_op;
        o_task.digit_a = i_digit_a;
        o_task.digit_b = i_digit_b;
        o_task.first   = i_first_digit;
        o_task.last    = i_last_digit;
        o_task.radix   = eff_radix;
        // range check wins over the zero divisor check
        if (({1'b0, i_digit_a} >= eff_radix) || ({1'b0, i_digit_b} >= eff_radix)) begin
            o_task.err = ERR_RANGE;
        end else if ((i_op == OP_DIV) && (i_digit_b == 4'd0)) begin
            o_task.err = ERR_DIV0;
        end else begin
            o_task.err = ERR_NONE;
        end
    end

    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full;

endmodule
`default_nettype wire

[hw/rtl/rdsa_queue.sv]
// Short task queue between front and back end.
// Depends on rdsa_pkg.
`default_nettype none
module rdsa_queue
    import rdsa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_task i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_task      o_data,
    output logic       o_empty
);

    t_task             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_rd;
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW:0]     r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/rdsa_back.sv]
// Back end: running carry, add/sub datapath, shared multiply plus radix-4
// restoring divider for multiply and divide, and the result queue.
// Depends on rdsa_pkg.
`default_nettype none
module rdsa_back
    import rdsa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_task      i_task,
    input  wire logic       i_q_empty,
    output logic            o_q_pop,
    output logic            empty,
    input  wire logic       pop,
    output t_result         o_result,
    output t_back_stat      o_stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [3:0]        r_carry;
    logic [3:0]        n_carry;
    t_task             r_task;
    logic [4:0]        r_rem;
    logic [7:0]        r_quo;
    logic [7:0]        r_dvd;
    logic [4:0]        r_dvs;
    logic [1:0]        r_step;

    t_result           r_buf [OUT_DEPTH];
    logic [OUT_AW-1:0] r_rd;
    logic [OUT_AW-1:0] r_wr;
    logic [OUT_CW-1:0] r_cnt;

    logic              start;
    logic              is_long;
    logic [3:0]        c_use;
    logic [4:0]        mul_x;
    logic [4:0]        mul_y;
    logic [3:0]        mul_z;
    logic [9:0]        prod;

    logic [4:0]        rem_a;
    logic [4:0]        rem_a2;
    logic [4:0]        rem_b;
    logic [4:0]        rem_b2;
    logic              ge_a;
    logic              ge_b;

    t_task             e_task;
    logic              emit;
    logic [4:0]        sum;
    logic [4:0]        sub;
    logic [4:0]        diff;
    logic [4:0]        rm1;
    logic [7:0]        qsat;
    logic [3:0]        d;
    logic [3:0]        nc;
    logic [1:0]        e_err;
    logic [3:0]        e_rem;
    logic [1:0]        n_push;
    t_result           n_res0;
    t_result           n_res1;
    logic              do_pop;

    // item start needs two free result slots so a carry pair always fits
    assign is_long = (i_task.err == ERR_NONE) && (i_task.op == OP_MUL || i_task.op == OP_DIV);
    assign start   = (r_state == S_IDLE) && !i_q_empty &&
                     (r_cnt <= OUT_CW'(OUT_DEPTH - 2));
    assign o_q_pop = start;
    assign c_use   = i_task.first ? 4'd0 : r_carry;

    // mul: a*b + c over radix; div: c*radix + a over b
    always_comb begin
        if (i_task.op == OP_MUL) begin
            mul_x = {1'b0, i_task.digit_a};
            mul_y = {1'b0, i_task.digit_b};
            mul_z = c_use;
        end else begin
            mul_x = {1'b0, c_use};
            mul_y = i_task.radix;
            mul_z = i_task.digit_a;
        end
        prod = mul_x * mul_y + {6'd0, mul_z};
    end

    // two restoring steps per cycle
    always_comb begin
        rem_a  = {r_rem[3:0], r_dvd[7]};
        ge_a   = (rem_a >= r_dvs);
        rem_a2 = ge_a ? rem_a - r_dvs : rem_a;
        rem_b  = {rem_a2[3:0], r_dvd[6]};
        ge_b   = (rem_b >= r_dvs);
        rem_b2 = ge_b ? rem_b - r_dvs : rem_b;
    end

    always_comb begin
        e_task = (r_state == S_FIN) ? r_task : i_task;
        emit   = (r_state == S_FIN) || (start && !is_long);
        sum    = {1'b0, e_task.digit_a} + {1'b0, e_task.digit_b} + {4'd0, c_use[0]};
        sub    = {1'b0, e_task.digit_b} + {4'd0, c_use[0]};
        rm1    = e_task.radix - 5'd1;
        qsat   = (r_quo > {3'd0, rm1}) ? {3'd0, rm1} : r_quo;
        d      = 4'd0;
        nc     = 4'd0;
        diff   = 5'd0;
        e_err  = ERR_NONE;
        e_rem  = 4'd0;
        case (e_task.op)
            OP_ADD: begin
                if (sum >= e_task.radix) begin
                    d  = 4'(sum - e_task.radix);
                    nc = 4'd1;
                end else begin
                    d  = sum[3:0];
                end
            end
            OP_SUB: begin
                if ({1'b0, e_task.digit_a} >= sub) begin
                    diff = {1'b0, e_task.digit_a} - sub;
                end else begin
                    diff = {1'b0, e_task.digit_a} + e_task.radix - sub;
                    nc   = 4'd1;
                    if (e_task.last) begin
                        e_err = ERR_NEG;
                    end
                end
                d = diff[3:0];
            end
            OP_MUL: begin
                d  = r_rem[3:0];
                nc = r_quo[3:0];
            end
            OP_DIV: begin
                d  = qsat[3:0];
                nc = r_rem[3:0];
                if (e_task.last) begin
                    e_rem = r_rem[3:0];
                end
            end
            default: begin
                d  = 4'd0;
                nc = 4'd0;
            end
        endcase

        n_push  = 2'd0;
        n_res0  = '0;
        n_res1  = '0;
        n_carry = r_carry;
        if (emit) begin
            n_push = 2'd1;
            if ((r_state == S_IDLE) && (e_task.err != ERR_NONE)) begin
                // flagged item: carry untouched apart from first/last clears
                n_res0.last = e_task.last;
                n_res0.err  = e_task.err;
                n_carry     = e_task.last ? 4'd0 : c_use;
            end else if (e_task.last) begin
                n_carry = 4'd0;
                if ((e_task.op == OP_ADD || e_task.op == OP_MUL) && (nc != 4'd0)) begin
                    n_push       = 2'd2;
                    n_res0.digit = d;
                    n_res1.digit = nc;
                    n_res1.last  = 1'b1;
                end else begin
                    n_res0.digit = d;
                    n_res0.rem   = e_rem;
                    n_res0.last  = 1'b1;
                    n_res0.err   = e_err;
                end
            end else begin
                n_carry      = nc;
                n_res0.digit = d;
                n_res0.err   = e_err;
            end
        end

        case (r_state)
            S_IDLE:  n_state = (start && is_long) ? S_DIV : S_IDLE;
            S_DIV:   n_state = (r_step == 2'd3) ? S_FIN : S_DIV;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_carry <= 4'd0;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_carry <= n_carry;
            if (r_state == S_DIV) begin
                r_step <= r_step + 2'd1;
            end else begin
                r_step <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && is_long) begin
            r_task <= i_task;
            r_dvd  <= prod[7:0];
            r_dvs  <= (i_task.op == OP_MUL) ? i_task.radix : {1'b0, i_task.digit_b};
            r_rem  <= 5'd0;
            r_quo  <= 8'd0;
        end else if (r_state == S_DIV) begin
            r_dvd  <= {r_dvd[5:0], 2'b00};
            r_rem  <= rem_b2;
            r_quo  <= {r_quo[5:0], ge_a, ge_b};
        end
    end

    // result queue
    assign empty    = (r_cnt == '0);
    assign do_pop   = pop && !empty;
    assign o_result = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + OUT_AW'(n_push);
            if (do_pop) begin
                r_rd <= r_rd + OUT_AW'(1);
            end
            r_cnt <= r_cnt + OUT_CW'(n_push) - OUT_CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_buf[r_wr] <= n_res0;
        end
        if (n_push == 2'd2) begin
            r_buf[r_wr + OUT_AW'(1)] <= n_res1;
        end
    end

    assign o_stat.busy      = (r_state != S_IDLE);
    assign o_stat.out_count = r_cnt;

endmodule
`default_nettype wire

[hw/rtl/radix_digit_serial_alu.sv]
// Top level of the radix digit-serial ALU: front end, task queue, back end.
// Depends on rdsa_pkg, rdsa_front, rdsa_queue, rdsa_back and the assert header.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------------
//  input     | push / full               | i_op i_digit_a i_digit_b i_first_digit i_last_digit
//  result    | empty / pop               | o_result_digit o_remainder_digit o_last_result o_error_code
//  config    | i_cfg_valid / o_cfg_ready | i_cfg_radix
//
// Add, subtract and flagged items are written back in the cycle they start; multiply and divide
// pass through a multiply step, the 2-bit-per-cycle divider and a write-back state.
// A transfer in is accepted while the two-entry task queue has room.
// An item starts only with two free slots in the four-entry result queue.
// Synchronous active-low reset clears queues, carry and radix (10); no clearing pass.
`default_nettype none
`include "radix_digit_serial_alu_assert.svh"
module radix_digit_serial_alu
    import rdsa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [4:0] i_cfg_radix,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_op,
    input  wire logic [3:0] i_digit_a,
    input  wire logic [3:0] i_digit_b,
    input  wire logic       i_first_digit,
    input  wire logic       i_last_digit,
    output logic            empty,
    input  wire logic       pop,
    output logic [3:0]      o_result_digit,
    output logic [3:0]      o_remainder_digit,
    output logic            o_last_result,
    output logic [1:0]      o_error_code
);

    t_task      f_task;
    t_task      q_task;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    logic       q_long;
    t_result    res;
    t_back_stat stat;

    rdsa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_radix   (i_cfg_radix),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_digit_a     (i_digit_a),
        .i_digit_b     (i_digit_b),
        .i_first_digit (i_first_digit),
        .i_last_digit  (i_last_digit),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_task        (f_task)
    );

    rdsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_task),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_task),
        .o_empty (q_empty)
    );

    rdsa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_task    (q_task),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (res),
        .o_stat    (stat)
    );

    assign o_result_digit    = res.digit;
    assign o_remainder_digit = res.rem;
    assign o_last_result     = res.last;
    assign o_error_code      = res.err;

    // a clean multiply or divide leaving the task queue
    assign q_long = q_pop && (q_task.err == ERR_NONE) &&
                    (q_task.op == OP_MUL || q_task.op == OP_DIV);

    `RDSA_ASSERT_IMP(a_qpop_nonempty, i_clk, i_rst_n, q_pop, !q_empty)
    `RDSA_ASSERT_IMP(a_qpush_room, i_clk, i_rst_n, q_push, !q_full)
    `RDSA_ASSERT_IMP(a_pop_when_idle, i_clk, i_rst_n, q_pop, !stat.busy)
    `RDSA_ASSERT_NXT(a_long_goes_busy, i_clk, i_rst_n, q_long, stat.busy)
    `RDSA_ASSERT_IMP(a_out_bound, i_clk, i_rst_n, 1'b1, stat.out_count <= OUT_CW'(OUT_DEPTH))

endmodule
`default_nettype wire
